// ===== sv/masked_box_blur_3x3_core_macros.svh =====
// ----------------------------------------------------------------------------
// masked box blur assertion macros
// shared concurrent check forms, sampled on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef MASKED_BOX_BLUR_3X3_CORE_MACROS_SVH
`define MASKED_BOX_BLUR_3X3_CORE_MACROS_SVH

// invariant that holds at every edge out of reset
`define MBB_CHK_HOLD(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication in the same cycle
`define MBB_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the following cycle
`define MBB_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mbb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbb_pkg
// shared constants, types and the reciprocal table of the masked box blur
// ----------------------------------------------------------------------------
`default_nettype none

package mbb_pkg;

	localparam int DEF_MAX_SIDE     = 1024;
	localparam int DEF_CHANNEL_BITS = 16;
	localparam int CFG_BITS         = 11;
	localparam int PIX_BITS         = 16;
	localparam int DATA_BITS        = 3 * PIX_BITS;
	localparam int RECIP_SHIFT      = 24;
	localparam int RECIP_BITS       = RECIP_SHIFT + 1;
	localparam int COUNT_BITS       = 4;

	// tuser bit positions on the input side
	localparam int USER_MODE = 0;
	localparam int USER_KEEP = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_ZS,
		ST_ROWS,
		ST_COL,
		ST_TOT,
		ST_MUL,
		ST_OUT
	} state_t;

	// per word plan decided at accept time
	typedef struct packed {
		logic zs;
		logic col;
		logic line_wr;
		logic emit;
		logic early;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} plan_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd;
		logic zs;
		logic col;
		logic line_wr;
		logic rows;
		logic tot;
		logic mul;
		logic out_load;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;
	} sts_t;

	// ceil(2^RECIP_SHIFT / n), exact for sums below 2^20
	function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] n);
		logic [RECIP_BITS-1:0] m;
		case (n)
			4'd1: m = RECIP_BITS'(25'd16777216);
			4'd2: m = RECIP_BITS'(25'd8388608);
			4'd3: m = RECIP_BITS'(25'd5592406);
			4'd4: m = RECIP_BITS'(25'd4194304);
			4'd6: m = RECIP_BITS'(25'd2796203);
			4'd9: m = RECIP_BITS'(25'd1864136);
			default: m = RECIP_BITS'(25'd16777216);
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/masked_box_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// masked_box_blur_3x3_core
// 3x3 box blur of a square rgb image with a per pixel keep flag
//
//   channel  dir  handshake           payload
//   cfg      in   cfg_we              cfg_wdata = image side
//   s        in   s_tvalid/s_tready   tdata rgb, tuser mode and keep flag
//   m        out  m_tvalid/m_tready   tdata rgb, tlast frame end
//
// the sequencer steps each word through line buffer read, window shift, sums,
// reciprocal multiply and output load, and takes the next word only once back
// in idle. a word without a result ends after the window shift; a drain word
// with nothing pending is dropped in idle. no clearing pass after reset.
// a held result stalls the sequencer only in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_box_blur_3x3_core
	import mbb_pkg::*;
#(
	parameter int MAX_SIDE     = DEF_MAX_SIDE,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_BITS-1:0]  cfg_wdata,  // image_side
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [DATA_BITS-1:0] s_tdata,    // in_red, in_green, in_blue
	input  wire logic [1:0]           s_tuser,    // keep_sharp, mode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DATA_BITS-1:0]      m_tdata,    // out_red, out_green, out_blue
	output logic                      m_tlast     // frame_end
);

	localparam int CW = $clog2(MAX_SIDE + 2);
	localparam int AW = $clog2(MAX_SIDE);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] addr;

	mbb_ctrl #(
		.MAX_SIDE (MAX_SIDE),
		.CW       (CW),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.in_mode   (s_tuser[USER_MODE]),
		.sts       (sts),
		.cmd       (cmd),
		.addr      (addr)
	);

	mbb_datapath #(
		.MAX_SIDE     (MAX_SIDE),
		.CHANNEL_BITS (CHANNEL_BITS),
		.AW           (AW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.addr     (addr),
		.in_data  (s_tdata),
		.in_keep  (s_tuser[USER_KEEP]),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/mbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbb_ctrl
// position counters, frame bookkeeping and the sequencer that walks one word
// through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module mbb_ctrl
	import mbb_pkg::*;
#(
	parameter int MAX_SIDE = DEF_MAX_SIDE,
	parameter int CW       = $clog2(MAX_SIDE + 2),
	parameter int AW       = $clog2(MAX_SIDE)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_BITS-1:0] cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic                in_mode,
	input  wire sts_t                sts,
	output cmd_t                     cmd,
	output logic [AW-1:0]            addr
);

	state_t        state_q, state_d;
	logic [CW-1:0] side_q, row_q, col_q;
	logic [CW-1:0] r, c, nr, nc, side1;
	logic [AW-1:0] addr_q;
	plan_t         plan_q, plan_d;
	logic          accept, ignore, pix, restart, eb;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign addr     = addr_q;

	// plan for the word at the port
	always_comb begin
		pix     = !in_mode;
		restart = pix && (row_q >= side_q);
		ignore  = in_mode && (row_q < side_q);
		r       = restart ? '0 : row_q;
		c       = restart ? '0 : col_q;
		side1   = side_q + 1'b1;
		plan_d.zs      = (c == '0);
		plan_d.early   = (c == '0) && (r >= CW'(2));
		plan_d.col     = (r <= side_q) && (c < side_q);
		eb             = plan_d.col && (c != '0) && (r != '0);
		plan_d.emit    = plan_d.early || eb;
		plan_d.line_wr = pix && (r < side_q);
		if (plan_d.early) begin
			plan_d.top   = (r != CW'(2));
			plan_d.bot   = (r <= side_q);
			plan_d.left  = (side_q != CW'(1));
			plan_d.right = 1'b0;
			plan_d.last  = (r == side1);
		end else begin
			plan_d.top   = (r != CW'(1));
			plan_d.bot   = (r < side_q);
			plan_d.left  = (c != CW'(1));
			plan_d.right = 1'b1;
			plan_d.last  = 1'b0;
		end
		if (r >= side1) begin
			nr = '0;
			nc = '0;
		end else if (c + 1'b1 >= side_q) begin
			nr = r + 1'b1;
			nc = '0;
		end else begin
			nr = r;
			nc = c + 1'b1;
		end
	end

	// side register and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= CW'(MAX_SIDE);
			row_q  <= '0;
			col_q  <= '0;
			plan_q <= '0;
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				side_q <= CW'(1);
			end else if (32'(cfg_wdata) > 32'(MAX_SIDE)) begin
				side_q <= CW'(MAX_SIDE);
			end else begin
				side_q <= CW'(cfg_wdata);
			end
			row_q <= '0;
			col_q <= '0;
		end else if (accept && !ignore) begin
			row_q  <= nr;
			col_q  <= nc;
			plan_q <= plan_d;
		end
	end

	// line buffer address of the word in flight
	always_ff @(posedge clk) begin
		if (accept && !ignore) begin
			addr_q <= c[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && !ignore) state_d = ST_RD;
			ST_RD:   state_d = ST_ZS;
			ST_ZS:   state_d = plan_q.early ? ST_ROWS : ST_COL;
			ST_ROWS: state_d = plan_q.early ? ST_COL : ST_TOT;
			ST_COL: begin
				if (plan_q.emit && !plan_q.early) begin
					state_d = ST_ROWS;
				end else if (plan_q.emit) begin
					state_d = ST_TOT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TOT:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT:  if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.load     = accept && !ignore;
		cmd.rd       = (state_q == ST_RD);
		cmd.zs       = (state_q == ST_ZS) && plan_q.zs;
		cmd.col      = (state_q == ST_COL) && plan_q.col;
		cmd.line_wr  = (state_q == ST_COL) && plan_q.line_wr;
		cmd.rows     = (state_q == ST_ROWS);
		cmd.tot      = (state_q == ST_TOT);
		cmd.mul      = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_OUT) && !sts.out_busy;
		cmd.top      = plan_q.top;
		cmd.bot      = plan_q.bot;
		cmd.left     = plan_q.left;
		cmd.right    = plan_q.right;
		cmd.last     = plan_q.last;
	end

`include "masked_box_blur_3x3_core_macros.svh"

	`MBB_CHK_HOLD(a_row_range, row_q <= side_q + 1'b1, "input row beyond drain rows")
	`MBB_CHK_HOLD(a_col_range, col_q < side_q, "input column beyond image side")
	`MBB_CHK_NEXT(a_out_done, state_q == ST_OUT && !sts.out_busy, state_q == ST_IDLE,
		"result handed over but sequencer did not return to idle")

endmodule

`default_nettype wire

// ===== sv/mbb_datapath.sv =====
// ----------------------------------------------------------------------------
// mbb_datapath
// line buffers, 3x3 window, masked sums, reciprocal divide and output register
// ----------------------------------------------------------------------------
`default_nettype none

module mbb_datapath
	import mbb_pkg::*;
#(
	parameter int MAX_SIDE     = DEF_MAX_SIDE,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
	parameter int AW           = $clog2(MAX_SIDE)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic [AW-1:0]        addr,
	input  wire logic [DATA_BITS-1:0] in_data,
	input  wire logic                 in_keep,
	output sts_t                      sts,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DATA_BITS-1:0]      m_tdata,
	output logic                      m_tlast
);

	localparam int CB = CHANNEL_BITS;
	localparam int EW = 3 * CB + 1;
	localparam int RW = CB + 2;
	localparam int SW = CB + 4;
	localparam int PW = SW + RECIP_BITS;

	logic [EW-1:0] upper_mem [MAX_SIDE];
	logic [EW-1:0] middle_mem [MAX_SIDE];
	logic [EW-1:0] entry_q, up_rd_q, mid_rd_q, centre_q;
	logic [EW-1:0] win_q [9];
	logic [EW-1:0] new_col [3];
	logic [RW-1:0] rsum_d [3][3];
	logic [RW-1:0] rsum_q [3][3];
	logic [SW-1:0] sum_d [3];
	logic [SW-1:0] sum_q [3];
	logic [PW-1:0] prod_q [3];
	logic [COUNT_BITS-1:0] n_d, n_q;
	logic [1:0]    nrow, ncol;
	logic          keep_q;
	logic          out_vq, out_last_q;
	logic [DATA_BITS-1:0] out_q;

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_q <= {in_keep, in_data[2*PIX_BITS +: CB], in_data[PIX_BITS +: CB],
				in_data[0 +: CB]};
		end
	end

	// line buffer two rows back
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			up_rd_q <= upper_mem[addr];
		end
		if (cmd.line_wr) begin
			upper_mem[addr] <= mid_rd_q;
		end
	end

	// line buffer one row back
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			mid_rd_q <= middle_mem[addr];
		end
		if (cmd.line_wr) begin
			middle_mem[addr] <= entry_q;
		end
	end

	// column entering the window
	always_comb begin
		new_col[0] = up_rd_q;
		new_col[1] = mid_rd_q;
		new_col[2] = cmd.line_wr ? entry_q : '0;
	end

	// window shift, zero column or line buffer column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.zs || cmd.col) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
				win_q[i*3+2] <= cmd.col ? new_col[i] : '0;
			end
		end
	end

	// per row masked sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				rsum_d[i][k] = RW'(win_q[i*3+1][k*CB +: CB])
					+ (cmd.left ? RW'(win_q[i*3][k*CB +: CB]) : '0)
					+ (cmd.right ? RW'(win_q[i*3+2][k*CB +: CB]) : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rows) begin
			rsum_q   <= rsum_d;
			centre_q <= win_q[4];
			keep_q   <= win_q[4][3*CB];
		end
	end

	// column sums and divisor
	always_comb begin
		nrow = 2'd1 + {1'b0, cmd.top} + {1'b0, cmd.bot};
		ncol = 2'd1 + {1'b0, cmd.left} + {1'b0, cmd.right};
		if (keep_q) begin
			n_d = COUNT_BITS'(1);
			for (int k = 0; k < 3; k++) begin
				sum_d[k] = SW'(centre_q[k*CB +: CB]);
			end
		end else begin
			n_d = COUNT_BITS'(nrow) * COUNT_BITS'(ncol);
			for (int k = 0; k < 3; k++) begin
				sum_d[k] = SW'(rsum_q[1][k])
					+ (cmd.top ? SW'(rsum_q[0][k]) : '0)
					+ (cmd.bot ? SW'(rsum_q[2][k]) : '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tot) begin
			sum_q <= sum_d;
			n_q   <= n_d;
		end
	end

	// divide by reciprocal multiply
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) begin
				prod_q[k] <= PW'(sum_q[k]) * PW'(recip(n_q));
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vq <= 1'b0;
		end else if (cmd.out_load) begin
			out_vq <= 1'b1;
		end else if (m_tready) begin
			out_vq <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int k = 0; k < 3; k++) begin
				out_q[k*PIX_BITS +: PIX_BITS] <= PIX_BITS'(prod_q[k][RECIP_SHIFT +: CB]);
			end
			out_last_q <= cmd.last;
		end
	end

	assign sts.out_busy = out_vq && !m_tready;
	assign m_tvalid     = out_vq;
	assign m_tdata      = out_q;
	assign m_tlast      = out_last_q;

`include "masked_box_blur_3x3_core_macros.svh"

	`MBB_CHK_NOW(a_divisor, cmd.mul,
		n_q == 4'd1 || n_q == 4'd2 || n_q == 4'd3 || n_q == 4'd4 || n_q == 4'd6 || n_q == 4'd9,
		"neighbourhood count is not a valid divisor")
	`MBB_CHK_NOW(a_no_overwrite, cmd.out_load, !out_vq || m_tready,
		"output register overwritten while still held")
	`MBB_CHK_NOW(a_valid_src, $rose(out_vq), $past(cmd.out_load),
		"output valid rose without a load")

endmodule

`default_nettype wire
